@@ rtl/spsa_pkg.sv @@
// Shared constants, types and helpers for the slotted page slot allocator.
`default_nettype none
package spsa_pkg;

	localparam int PAGE_BYTES   = 4096;
	localparam int HEADER_BYTES = 16;
	localparam int ENTRY_BYTES  = 5;
	localparam int MAX_SLOTS    = 64;

	localparam int BW = 13;
	localparam int IW = 6;
	localparam int CW = 7;

	typedef enum logic [1:0] {
		CMD_INIT   = 2'd0,
		CMD_ALLOC  = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_VACUUM = 2'd3
	} cmd_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_BADSLOT = 2'd2;

	typedef enum logic [3:0] {
		OP_IDLE, OP_INIT, OP_ASCAN, OP_ARD, OP_ACHK, OP_AAPP, OP_DCHK, OP_DOUT,
		OP_VPRE, OP_SRD, OP_SEV, OP_UPD, OP_ERD1, OP_ERD2, OP_EOUT
	} op_t;

	typedef struct packed {
		logic load;
		op_t  op;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_zero;
		logic scan_hit;
		logic del_bad;
		logic idx_end;
		logic nlive_zero;
		logic k_last;
	} dp_sts_t;

	// free bytes between directory end and data start, floored at zero
	function automatic logic [BW-1:0] free_sp(input logic [BW-1:0] fe, input logic [CW-1:0] dl);
		logic [BW-1:0] st;
		st = BW'(HEADER_BYTES) + BW'(int'(dl) * ENTRY_BYTES);
		return (fe > st) ? fe - st : '0;
	endfunction

endpackage
`default_nettype wire

@@ rtl/spsa_ctrl.sv @@
// Sequencing state machine for the slot allocator.
`default_nettype none
module spsa_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [1:0]        command,
	input  wire spsa_pkg::dp_sts_t sts,
	output spsa_pkg::ctl_cmd_t     cmd,
	output logic                   busy
);

	typedef enum logic [14:0] {
		S_IDLE  = 15'h0001,
		S_INIT  = 15'h0002,
		S_ASCAN = 15'h0004,
		S_ARD   = 15'h0008,
		S_ACHK  = 15'h0010,
		S_AAPP  = 15'h0020,
		S_DCHK  = 15'h0040,
		S_DOUT  = 15'h0080,
		S_VPRE  = 15'h0100,
		S_SRD   = 15'h0200,
		S_SEV   = 15'h0400,
		S_UPD   = 15'h0800,
		S_ERD1  = 15'h1000,
		S_ERD2  = 15'h2000,
		S_EOUT  = 15'h4000
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (spsa_pkg::cmd_t'(command))
						spsa_pkg::CMD_INIT:   state_d = S_INIT;
						spsa_pkg::CMD_ALLOC:  state_d = S_ASCAN;
						spsa_pkg::CMD_DELETE: state_d = S_DCHK;
						spsa_pkg::CMD_VACUUM: state_d = S_VPRE;
						default:              state_d = S_IDLE;
					endcase
				end
			end
			S_INIT:  state_d = S_IDLE;
			S_ASCAN: begin
				if (sts.scan_zero)
					state_d = S_AAPP;
				else if (sts.scan_hit)
					state_d = S_ARD;
			end
			S_ARD:   state_d = S_ACHK;
			S_ACHK:  state_d = S_IDLE;
			S_AAPP:  state_d = S_IDLE;
			S_DCHK:  state_d = sts.del_bad ? S_IDLE : S_DOUT;
			S_DOUT:  state_d = S_IDLE;
			S_VPRE: begin
				if (sts.idx_end)
					state_d = sts.nlive_zero ? S_IDLE : S_SRD;
			end
			S_SRD:   state_d = sts.idx_end ? S_UPD : S_SEV;
			S_SEV:   state_d = S_SRD;
			S_UPD:   state_d = sts.k_last ? S_ERD1 : S_SRD;
			S_ERD1:  state_d = S_ERD2;
			S_ERD2:  state_d = S_EOUT;
			S_EOUT:  state_d = sts.k_last ? S_IDLE : S_ERD1;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.load = start && (state_q == S_IDLE);
		case (state_q)
			S_INIT:  cmd.op = spsa_pkg::OP_INIT;
			S_ASCAN: cmd.op = spsa_pkg::OP_ASCAN;
			S_ARD:   cmd.op = spsa_pkg::OP_ARD;
			S_ACHK:  cmd.op = spsa_pkg::OP_ACHK;
			S_AAPP:  cmd.op = spsa_pkg::OP_AAPP;
			S_DCHK:  cmd.op = spsa_pkg::OP_DCHK;
			S_DOUT:  cmd.op = spsa_pkg::OP_DOUT;
			S_VPRE:  cmd.op = spsa_pkg::OP_VPRE;
			S_SRD:   cmd.op = spsa_pkg::OP_SRD;
			S_SEV:   cmd.op = spsa_pkg::OP_SEV;
			S_UPD:   cmd.op = spsa_pkg::OP_UPD;
			S_ERD1:  cmd.op = spsa_pkg::OP_ERD1;
			S_ERD2:  cmd.op = spsa_pkg::OP_ERD2;
			S_EOUT:  cmd.op = spsa_pkg::OP_EOUT;
			default: cmd.op = spsa_pkg::OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule
`default_nettype wire

@@ rtl/spsa_dp.sv @@
// Directory storage, scan counters, vacuum sort and result registers.
`default_nettype none
module spsa_dp (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire spsa_pkg::ctl_cmd_t      cmd,
	input  wire logic [1:0]              command,
	input  wire logic [spsa_pkg::BW-1:0] request_size,
	input  wire logic [spsa_pkg::IW-1:0] slot_index,
	output spsa_pkg::dp_sts_t            sts,
	output logic                         result_valid,
	output logic [1:0]                   status,
	output logic [spsa_pkg::IW-1:0]      slot_number,
	output logic [spsa_pkg::BW-1:0]      new_offset,
	output logic [spsa_pkg::BW-1:0]      old_offset,
	output logic [spsa_pkg::BW-1:0]      byte_count,
	output logic [spsa_pkg::BW-1:0]      free_bytes,
	output logic                         is_move,
	output logic                         last
);

	localparam int BW = spsa_pkg::BW;
	localparam int IW = spsa_pkg::IW;
	localparam int CW = spsa_pkg::CW;
	localparam int NS = spsa_pkg::MAX_SLOTS;

	// directory memories
	logic [BW-1:0] off_mem [NS];
	logic [BW-1:0] sz_mem  [NS];
	logic [IW-1:0] ord_slot_mem [NS];
	logic [BW-1:0] ord_old_mem  [NS];

	logic [NS-1:0] deleted_q;
	logic [NS-1:0] taken_q;
	logic [CW-1:0] dl_q, live_q, i_q, k_q, nlive_q;
	logic [BW-1:0] free_end_q, end_q, size_q;
	logic [IW-1:0] idx_q, pick_q, best_q;
	logic [BW-1:0] best_off_q, best_sz_q;
	logic          have_q;
	logic [BW-1:0] off_rd_q, sz_rd_q, ord_old_rd_q;
	logic [IW-1:0] ord_slot_rd_q;

	logic [IW-1:0] i_lo, i_dec, rd_addr;
	logic [BW-1:0] fs_now, fe_sub, fs_grow, fs_app, end_new;
	logic          shrink, grow_fail, app_fail, a_ok;
	logic          off_we, sz_we;
	logic [IW-1:0] off_wa, sz_wa;
	logic [BW-1:0] off_wd, sz_wd;

	logic          r_vld, r_mv, r_last;
	logic [1:0]    r_st;
	logic [IW-1:0] r_slot;
	logic [BW-1:0] r_new, r_old, r_cnt, r_free;

	assign i_lo  = i_q[IW-1:0];
	assign i_dec = IW'(i_q - CW'(1));

	assign fs_now  = spsa_pkg::free_sp(free_end_q, dl_q);
	assign fe_sub  = free_end_q - size_q;
	assign fs_grow = spsa_pkg::free_sp(fe_sub, dl_q);
	assign fs_app  = spsa_pkg::free_sp(fe_sub, dl_q + CW'(1));
	assign end_new = (best_sz_q > end_q) ? '0 : end_q - best_sz_q;

	assign shrink    = size_q < sz_rd_q;
	assign grow_fail = size_q > fs_now;
	assign a_ok      = shrink || !grow_fail;
	assign app_fail  = (dl_q >= CW'(NS)) ||
		({1'b0, fs_now} < ((BW+1)'(spsa_pkg::ENTRY_BYTES) + {1'b0, size_q}));

	always_comb begin
		sts.scan_zero  = (i_q == '0);
		sts.scan_hit   = (i_q != '0) && deleted_q[i_dec];
		sts.del_bad    = ({1'b0, idx_q} >= dl_q) || deleted_q[idx_q];
		sts.idx_end    = (i_q == dl_q);
		sts.nlive_zero = (nlive_q == '0);
		sts.k_last     = ((k_q + CW'(1)) == nlive_q);
	end

	always_comb begin
		case (cmd.op)
			spsa_pkg::OP_DCHK: rd_addr = idx_q;
			spsa_pkg::OP_SRD:  rd_addr = i_lo;
			spsa_pkg::OP_ERD2: rd_addr = ord_slot_rd_q;
			default:           rd_addr = pick_q;
		endcase
	end

	always_comb begin
		off_we = 1'b0;
		off_wa = pick_q;
		off_wd = fe_sub;
		sz_we  = 1'b0;
		sz_wa  = pick_q;
		sz_wd  = size_q;
		case (cmd.op)
			spsa_pkg::OP_ACHK: begin
				off_we = !shrink && !grow_fail;
				sz_we  = a_ok;
			end
			spsa_pkg::OP_AAPP: begin
				off_we = !app_fail;
				off_wa = dl_q[IW-1:0];
				sz_we  = !app_fail;
				sz_wa  = dl_q[IW-1:0];
			end
			spsa_pkg::OP_VPRE: begin
				sz_we = !sts.idx_end && deleted_q[i_lo];
				sz_wa = i_lo;
				sz_wd = '0;
			end
			spsa_pkg::OP_UPD: begin
				off_we = 1'b1;
				off_wa = best_q;
				off_wd = end_new;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (off_we)
			off_mem[off_wa] <= off_wd;
		off_rd_q <= off_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (sz_we)
			sz_mem[sz_wa] <= sz_wd;
		sz_rd_q <= sz_mem[rd_addr];
	end

	// vacuum order, written during the sort and read back for the moves
	always_ff @(posedge clk) begin
		if (cmd.op == spsa_pkg::OP_UPD) begin
			ord_slot_mem[k_q[IW-1:0]] <= best_q;
			ord_old_mem[k_q[IW-1:0]]  <= best_off_q;
		end
		ord_slot_rd_q <= ord_slot_mem[k_q[IW-1:0]];
		ord_old_rd_q  <= ord_old_mem[k_q[IW-1:0]];
	end

	always_comb begin
		r_vld  = 1'b0;
		r_st   = spsa_pkg::ST_OK;
		r_slot = '0;
		r_new  = '0;
		r_old  = '0;
		r_cnt  = '0;
		r_free = fs_now;
		r_mv   = 1'b0;
		r_last = 1'b1;
		case (cmd.op)
			spsa_pkg::OP_INIT: begin
				r_vld  = 1'b1;
				r_free = spsa_pkg::free_sp(BW'(spsa_pkg::PAGE_BYTES), '0);
			end
			spsa_pkg::OP_ACHK: begin
				r_vld = 1'b1;
				if (shrink) begin
					r_slot = pick_q;
					r_new  = off_rd_q;
					r_cnt  = size_q;
				end else if (grow_fail) begin
					r_st = spsa_pkg::ST_NOSPACE;
				end else begin
					r_slot = pick_q;
					r_new  = fe_sub;
					r_cnt  = size_q;
					r_free = fs_grow;
				end
			end
			spsa_pkg::OP_AAPP: begin
				r_vld = 1'b1;
				if (app_fail) begin
					r_st = spsa_pkg::ST_NOSPACE;
				end else begin
					r_slot = dl_q[IW-1:0];
					r_new  = fe_sub;
					r_cnt  = size_q;
					r_free = fs_app;
				end
			end
			spsa_pkg::OP_DCHK: begin
				r_vld = sts.del_bad;
				r_st  = spsa_pkg::ST_BADSLOT;
			end
			spsa_pkg::OP_DOUT: begin
				r_vld  = 1'b1;
				r_slot = idx_q;
				r_new  = off_rd_q;
				r_cnt  = sz_rd_q;
			end
			spsa_pkg::OP_VPRE: begin
				r_vld  = sts.idx_end && sts.nlive_zero;
				r_free = spsa_pkg::free_sp(BW'(spsa_pkg::PAGE_BYTES), dl_q);
			end
			spsa_pkg::OP_EOUT: begin
				r_vld  = 1'b1;
				r_slot = ord_slot_rd_q;
				r_new  = off_rd_q;
				r_old  = ord_old_rd_q;
				r_cnt  = sz_rd_q;
				r_mv   = 1'b1;
				r_last = sts.k_last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else
			result_valid <= r_vld;
	end

	always_ff @(posedge clk) begin
		if (r_vld) begin
			status      <= r_st;
			slot_number <= r_slot;
			new_offset  <= r_new;
			old_offset  <= r_old;
			byte_count  <= r_cnt;
			free_bytes  <= r_free;
			is_move     <= r_mv;
			last        <= r_last;
		end
	end

	// page state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deleted_q  <= '0;
			dl_q       <= '0;
			live_q     <= '0;
			free_end_q <= BW'(spsa_pkg::PAGE_BYTES);
		end else begin
			case (cmd.op)
				spsa_pkg::OP_INIT: begin
					deleted_q  <= '0;
					dl_q       <= '0;
					live_q     <= '0;
					free_end_q <= BW'(spsa_pkg::PAGE_BYTES);
				end
				spsa_pkg::OP_ACHK: begin
					if (a_ok) begin
						deleted_q[pick_q] <= 1'b0;
						live_q            <= live_q + CW'(1);
						if (!shrink)
							free_end_q <= fe_sub;
					end
				end
				spsa_pkg::OP_AAPP: begin
					if (!app_fail) begin
						deleted_q[dl_q[IW-1:0]] <= 1'b0;
						dl_q                    <= dl_q + CW'(1);
						live_q                  <= live_q + CW'(1);
						free_end_q              <= fe_sub;
					end
				end
				spsa_pkg::OP_DOUT: begin
					deleted_q[idx_q] <= 1'b1;
					if (live_q != '0)
						live_q <= live_q - CW'(1);
				end
				spsa_pkg::OP_VPRE: begin
					if (sts.idx_end && sts.nlive_zero)
						free_end_q <= BW'(spsa_pkg::PAGE_BYTES);
				end
				spsa_pkg::OP_UPD:  free_end_q <= end_new;
				default: ;
			endcase
		end
	end

	// scan and sort control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q     <= '0;
			k_q     <= '0;
			nlive_q <= '0;
			have_q  <= 1'b0;
			end_q   <= BW'(spsa_pkg::PAGE_BYTES);
		end else if (cmd.load) begin
			i_q     <= (spsa_pkg::cmd_t'(command) == spsa_pkg::CMD_ALLOC) ? dl_q : '0;
			k_q     <= '0;
			nlive_q <= '0;
			have_q  <= 1'b0;
			end_q   <= BW'(spsa_pkg::PAGE_BYTES);
		end else begin
			case (cmd.op)
				spsa_pkg::OP_ASCAN: begin
					if (!sts.scan_zero && !sts.scan_hit)
						i_q <= i_q - CW'(1);
				end
				spsa_pkg::OP_VPRE: begin
					if (sts.idx_end) begin
						i_q    <= '0;
						have_q <= 1'b0;
					end else begin
						i_q <= i_q + CW'(1);
						if (!deleted_q[i_lo])
							nlive_q <= nlive_q + CW'(1);
					end
				end
				spsa_pkg::OP_SEV: begin
					i_q <= i_q + CW'(1);
					if (!taken_q[i_lo] && (!have_q || off_rd_q > best_off_q))
						have_q <= 1'b1;
				end
				spsa_pkg::OP_UPD: begin
					i_q    <= '0;
					have_q <= 1'b0;
					end_q  <= end_new;
					k_q    <= sts.k_last ? '0 : k_q + CW'(1);
				end
				spsa_pkg::OP_EOUT: k_q <= k_q + CW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			size_q <= request_size;
			idx_q  <= slot_index;
		end
		if (cmd.op == spsa_pkg::OP_ASCAN && sts.scan_hit)
			pick_q <= i_dec;
		if (cmd.op == spsa_pkg::OP_VPRE && !sts.idx_end)
			taken_q[i_lo] <= deleted_q[i_lo];
		if (cmd.op == spsa_pkg::OP_SEV && !taken_q[i_lo] &&
			(!have_q || off_rd_q > best_off_q)) begin
			best_q     <= i_lo;
			best_off_q <= off_rd_q;
			best_sz_q  <= sz_rd_q;
		end
		if (cmd.op == spsa_pkg::OP_UPD)
			taken_q[best_q] <= 1'b1;
	end

endmodule
`default_nettype wire

@@ rtl/slotted_page_slot_allocator.sv @@
// Steps: init clears the page; delete checks the slot and, if good, reports and marks it;
// allocate scans down from the directory end for a deleted mark, then reads and checks the
// hit, or appends an entry if none is deleted. Vacuum marks the n directory entries, then
// for each of L live entries sweeps them for the max offset and updates; then reads out each move.
// A result word appears in the cycle after its step; busy falls with the last word.
// One item at a time; the next start is taken the cycle busy is low. Receiver cannot stall.
// Reset: empty directory, free end at page size, no results pending.
`default_nettype none
module slotted_page_slot_allocator (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [1:0]              command,
	input  wire logic [spsa_pkg::BW-1:0] request_size,
	input  wire logic [spsa_pkg::IW-1:0] slot_index,
	output logic                         result_valid,
	output logic [1:0]                   status,
	output logic [spsa_pkg::IW-1:0]      slot_number,
	output logic [spsa_pkg::BW-1:0]      new_offset,
	output logic [spsa_pkg::BW-1:0]      old_offset,
	output logic [spsa_pkg::BW-1:0]      byte_count,
	output logic [spsa_pkg::BW-1:0]      free_bytes,
	output logic                         is_move,
	output logic                         last
);

	spsa_pkg::ctl_cmd_t cmd;
	spsa_pkg::dp_sts_t  sts;

	spsa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.sts     (sts),
		.cmd     (cmd),
		.busy    (busy)
	);

	spsa_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.command      (command),
		.request_size (request_size),
		.slot_index   (slot_index),
		.sts          (sts),
		.result_valid (result_valid),
		.status       (status),
		.slot_number  (slot_number),
		.new_offset   (new_offset),
		.old_offset   (old_offset),
		.byte_count   (byte_count),
		.free_bytes   (free_bytes),
		.is_move      (is_move),
		.last         (last)
	);

endmodule
`default_nettype wire

@@ rtl/spsa_chk.sv @@
// Port-level checks for the slot allocator, bound to the top level.
`default_nettype none
module spsa_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       result_valid,
	input wire logic [1:0] status,
	input wire logic       is_move,
	input wire logic       last
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (last == !busy))
		else $error("busy does not end with the last result word");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (status == spsa_pkg::ST_OK || status == spsa_pkg::ST_NOSPACE ||
			status == spsa_pkg::ST_BADSLOT))
		else $error("undefined status code");

	a_move_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_move |-> status == spsa_pkg::ST_OK)
		else $error("move word carries a failure status");

endmodule

bind slotted_page_slot_allocator spsa_chk u_spsa_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.status       (status),
	.is_move      (is_move),
	.last         (last)
);
`default_nettype wire

@@ sim/slotted_page_slot_allocator_tb.sv @@
// Self-checking testbench for the slotted page slot allocator.
`timescale 1ns / 100ps
`default_nettype none
module slotted_page_slot_allocator_tb;

	typedef struct {
		logic [1:0]              command;
		logic [spsa_pkg::BW-1:0] request_size;
		logic [spsa_pkg::IW-1:0] slot_index;
	} command_word_t;

	typedef struct {
		logic [1:0]              status;
		logic [spsa_pkg::IW-1:0] slot_number;
		logic [spsa_pkg::BW-1:0] new_offset;
		logic [spsa_pkg::BW-1:0] old_offset;
		logic [spsa_pkg::BW-1:0] byte_count;
		logic [spsa_pkg::BW-1:0] free_bytes;
		logic                    is_move;
		logic                    last;
	} page_result_t;

	localparam int CYCLE_LIMIT = 20000000;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [1:0]              command;
	logic [spsa_pkg::BW-1:0] request_size;
	logic [spsa_pkg::IW-1:0] slot_index;
	logic                    result_valid;
	logic [1:0]              status;
	logic [spsa_pkg::IW-1:0] slot_number;
	logic [spsa_pkg::BW-1:0] new_offset;
	logic [spsa_pkg::BW-1:0] old_offset;
	logic [spsa_pkg::BW-1:0] byte_count;
	logic [spsa_pkg::BW-1:0] free_bytes;
	logic                    is_move;
	logic                    last;

	slotted_page_slot_allocator dut (.*);

	// page model state
	int  pg_offset [64];
	int  pg_size   [64];
	bit  pg_deleted[64];
	int  pg_dir_len;
	int  pg_live;
	int  pg_free_end;

	command_word_t pending_words[$];
	page_result_t  expected_results[$];
	int            mismatch_count;
	int            cycle_count;
	int            burst_left;
	int            gap_left;
	bit            hold_until_drained;
	bit            stimulus_done;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int page_free();
		int st;
		st = spsa_pkg::HEADER_BYTES + pg_dir_len * spsa_pkg::ENTRY_BYTES;
		return (pg_free_end > st) ? pg_free_end - st : 0;
	endfunction

	function automatic page_result_t make_result(logic [1:0] st, int slot, int newo, int oldo,
			int cnt, logic mv, logic lst);
		page_result_t r;
		r.status = st;
		r.slot_number = spsa_pkg::IW'(slot);
		r.new_offset = spsa_pkg::BW'(newo);
		r.old_offset = spsa_pkg::BW'(oldo);
		r.byte_count = spsa_pkg::BW'(cnt);
		r.free_bytes = spsa_pkg::BW'(page_free());
		r.is_move = mv;
		r.last = lst;
		return r;
	endfunction

	task automatic predict_page_step(input command_word_t w);
		int  pick;
		bit  found;
		int  sz;
		int  idx;
		int  run_end;
		int  nlive;
		int  best;
		bit  taken[64];
		int  ord_slot[64];
		int  ord_old[64];
		sz = int'(w.request_size);
		idx = int'(w.slot_index);
		case (spsa_pkg::cmd_t'(w.command))
			spsa_pkg::CMD_INIT: begin
				pg_dir_len = 0;
				pg_live = 0;
				pg_free_end = spsa_pkg::PAGE_BYTES;
				foreach (pg_deleted[i]) pg_deleted[i] = 1'b0;
				expected_results.push_back(make_result(spsa_pkg::ST_OK, 0, 0, 0, 0, 1'b0, 1'b1));
			end
			spsa_pkg::CMD_ALLOC: begin
				found = 1'b0;
				pick = 0;
				for (int i = 0; i < pg_dir_len; i++)
					if (pg_deleted[i]) begin
						found = 1'b1;
						pick = i;
					end
				if (found) begin
					if (sz < pg_size[pick]) begin
						pg_size[pick] = sz;
					end else if (sz > page_free()) begin
						expected_results.push_back(make_result(spsa_pkg::ST_NOSPACE, 0, 0, 0, 0,
							1'b0, 1'b1));
						return;
					end else begin
						pg_free_end -= sz;
						pg_offset[pick] = pg_free_end;
						pg_size[pick] = sz;
					end
				end else begin
					if (pg_dir_len >= spsa_pkg::MAX_SLOTS ||
						page_free() < spsa_pkg::ENTRY_BYTES + sz) begin
						expected_results.push_back(make_result(spsa_pkg::ST_NOSPACE, 0, 0, 0, 0,
							1'b0, 1'b1));
						return;
					end
					pick = pg_dir_len;
					pg_dir_len++;
					pg_free_end -= sz;
					pg_offset[pick] = pg_free_end;
					pg_size[pick] = sz;
				end
				pg_deleted[pick] = 1'b0;
				pg_live = (pg_live + 1) & 127;
				expected_results.push_back(make_result(spsa_pkg::ST_OK, pick, pg_offset[pick], 0,
					pg_size[pick], 1'b0, 1'b1));
			end
			spsa_pkg::CMD_DELETE: begin
				if (idx >= pg_dir_len || pg_deleted[idx]) begin
					expected_results.push_back(make_result(spsa_pkg::ST_BADSLOT, 0, 0, 0, 0,
						1'b0, 1'b1));
				end else begin
					pg_deleted[idx] = 1'b1;
					if (pg_live > 0) pg_live--;
					expected_results.push_back(make_result(spsa_pkg::ST_OK, idx, pg_offset[idx], 0,
						pg_size[idx], 1'b0, 1'b1));
				end
			end
			default: begin
				run_end = spsa_pkg::PAGE_BYTES;
				nlive = 0;
				for (int i = 0; i < 64; i++) taken[i] = 1'b0;
				for (int i = 0; i < pg_dir_len; i++)
					if (pg_deleted[i]) begin
						pg_size[i] = 0;
						taken[i] = 1'b1;
					end else nlive++;
				for (int k = 0; k < nlive; k++) begin
					best = -1;
					for (int i = 0; i < pg_dir_len; i++)
						if (!taken[i] && (best < 0 || pg_offset[i] > pg_offset[best]))
							best = i;
					taken[best] = 1'b1;
					ord_slot[k] = best;
					ord_old[k] = pg_offset[best];
					run_end = (pg_size[best] > run_end) ? 0 : run_end - pg_size[best];
					pg_offset[best] = run_end;
				end
				pg_free_end = run_end;
				if (nlive == 0)
					expected_results.push_back(make_result(spsa_pkg::ST_OK, 0, 0, 0, 0, 1'b0, 1'b1));
				for (int k = 0; k < nlive; k++)
					expected_results.push_back(make_result(spsa_pkg::ST_OK, ord_slot[k],
						pg_offset[ord_slot[k]], ord_old[k], pg_size[ord_slot[k]], 1'b1,
						k + 1 == nlive));
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("t=%0t %s: got %0d expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic queue_word(input spsa_pkg::cmd_t c, input int sz, input int idx);
		command_word_t w;
		w.command = c;
		w.request_size = spsa_pkg::BW'(sz);
		w.slot_index = spsa_pkg::IW'(idx);
		pending_words.push_back(w);
	endtask

	// random sizes: mostly small so the directory fills, a few large
	function automatic int pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(0, 64);
		if (r < 90) return $urandom_range(0, 600);
		if (r < 97) return $urandom_range(0, 4096);
		return $urandom_range(0, 8191);
	endfunction

	// driver: bursts and gaps, inputs change on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !busy) begin
			// word on the bus already taken and finished, so present the next or drop start
			if (burst_left > 0) burst_left--;
			if (pending_words.size() > 0 && burst_left > 0 && !hold_until_drained) begin
				command <= pending_words[0].command;
				request_size <= pending_words[0].request_size;
				slot_index <= pending_words[0].slot_index;
				predict_page_step(pending_words.pop_front());
			end else begin
				start <= 1'b0;
				gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			end
		end else if (!start) begin
			if (hold_until_drained && expected_results.size() == 0 && !busy)
				hold_until_drained = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_words.size() > 0 && !hold_until_drained && !busy) begin
				burst_left = $urandom_range(1, 20);
				start <= 1'b1;
				command <= pending_words[0].command;
				request_size <= pending_words[0].request_size;
				slot_index <= pending_words[0].slot_index;
				predict_page_step(pending_words.pop_front());
			end
		end
		if (pending_words.size() == 0 && !start && !busy) stimulus_done = 1'b1;
		else if (pending_words.size() > 0) stimulus_done = 1'b0;
	end

	// monitor
	always @(posedge clk) begin
		page_result_t e;
		cycle_count++;
		if (arst_n && result_valid) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result word, slot", slot_number, -1);
			end else begin
				e = expected_results.pop_front();
				if (status !== e.status) report_mismatch("status", status, e.status);
				if (slot_number !== e.slot_number)
					report_mismatch("slot_number", slot_number, e.slot_number);
				if (new_offset !== e.new_offset)
					report_mismatch("new_offset", new_offset, e.new_offset);
				if (old_offset !== e.old_offset)
					report_mismatch("old_offset", old_offset, e.old_offset);
				if (byte_count !== e.byte_count)
					report_mismatch("byte_count", byte_count, e.byte_count);
				if (free_bytes !== e.free_bytes)
					report_mismatch("free_bytes", free_bytes, e.free_bytes);
				if (is_move !== e.is_move) report_mismatch("is_move", is_move, e.is_move);
				if (last !== e.last) report_mismatch("last", last, e.last);
			end
		end
	end

	initial begin
		int r;
		arst_n = 1'b0;
		start = 1'b0;
		command = spsa_pkg::CMD_INIT;
		request_size = '0;
		slot_index = '0;
		mismatch_count = 0;
		cycle_count = 0;
		burst_left = 0;
		gap_left = 0;
		hold_until_drained = 1'b0;
		stimulus_done = 1'b0;
		pg_dir_len = 0;
		pg_live = 0;
		pg_free_end = spsa_pkg::PAGE_BYTES;
		foreach (pg_deleted[i]) pg_deleted[i] = 1'b0;

		// directed: empty page, extremes, reuse paths, bad deletes, full directory
		queue_word(spsa_pkg::CMD_VACUUM, 0, 0);
		queue_word(spsa_pkg::CMD_DELETE, 0, 63);
		queue_word(spsa_pkg::CMD_ALLOC, 8191, 0);
		queue_word(spsa_pkg::CMD_ALLOC, 0, 63);
		queue_word(spsa_pkg::CMD_ALLOC, 100, 0);
		queue_word(spsa_pkg::CMD_ALLOC, 200, 0);
		queue_word(spsa_pkg::CMD_DELETE, 0, 1);
		queue_word(spsa_pkg::CMD_DELETE, 0, 1);
		queue_word(spsa_pkg::CMD_DELETE, 0, 3);
		queue_word(spsa_pkg::CMD_ALLOC, 50, 0);
		queue_word(spsa_pkg::CMD_DELETE, 0, 2);
		queue_word(spsa_pkg::CMD_ALLOC, 300, 0);
		queue_word(spsa_pkg::CMD_DELETE, 0, 0);
		queue_word(spsa_pkg::CMD_ALLOC, 5000, 0);
		queue_word(spsa_pkg::CMD_VACUUM, 0, 0);
		queue_word(spsa_pkg::CMD_ALLOC, 4096, 0);
		queue_word(spsa_pkg::CMD_INIT, 8191, 63);
		queue_word(spsa_pkg::CMD_ALLOC, 4075, 0);
		queue_word(spsa_pkg::CMD_ALLOC, 0, 0);
		queue_word(spsa_pkg::CMD_INIT, 0, 0);
		for (int i = 0; i < 65; i++) queue_word(spsa_pkg::CMD_ALLOC, i % 3, 0);
		queue_word(spsa_pkg::CMD_VACUUM, 0, 0);

		#24 arst_n = 1'b1;

		// random: mostly allocate/delete traffic, occasional vacuum and init
		for (int n = 0; n < 374; n++) begin
			r = $urandom_range(0, 99);
			if (r < 50) queue_word(spsa_pkg::CMD_ALLOC, pick_size(), $urandom_range(0, 63));
			else if (r < 85)
				queue_word(spsa_pkg::CMD_DELETE, $urandom_range(0, 8191),
					$urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
						: $urandom_range(0, pg_dir_len > 0 ? 40 : 63));
			else if (r < 96)
				queue_word(spsa_pkg::CMD_VACUUM, $urandom_range(0, 8191),
					$urandom_range(0, 63));
			else
				queue_word(spsa_pkg::CMD_INIT, $urandom_range(0, 8191), $urandom_range(0, 63));
			if (n == 230) begin
				wait (pending_words.size() < 5);
				hold_until_drained = 1'b1;
			end
		end

		while (!(stimulus_done && expected_results.size() == 0) && cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
		end else if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
`default_nettype wire
